@@ rtl/dbdma_pkg.sv @@
// Shared types and constants of the double-buffer DMA transfer control block.
`default_nettype none
package dbdma_pkg;

  localparam int unsigned CountW = 32;
  localparam int unsigned CntW   = 16;
  localparam int unsigned ProdW  = CountW + 2;

  localparam logic [CountW-1:0] MaxTransferBytes = 32'd16777215;
  localparam logic [CntW-1:0]   MaxCount         = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_START    = 2'd0,
    KIND_COMPLETE = 2'd1,
    KIND_CLEAR    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_BUSY     = 2'd2,
    ST_NO_SPLIT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_TX_DIRECTION = 2'd0,
    CFG_ELEMENT_SIZE = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ESIZE_HALF = 2'd1,
    ESIZE_WORD = 2'd2
  } esize_e;

  typedef enum logic [1:0] {
    SP_IDLE,
    SP_DIV,
    SP_CHECK,
    SP_SEARCH
  } split_state_e;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_SPLIT,
    TOP_EMIT
  } top_state_e;

  typedef struct packed {
    logic              start;
    logic [CountW-1:0] count;
    logic [CntW-1:0]   frames;
  } split_req_t;

  typedef struct packed {
    logic            done;
    logic            ok;
    logic [CntW-1:0] elements;
    logic [CntW-1:0] frames;
  } split_rsp_t;

endpackage
`default_nettype wire

@@ rtl/double_buffer_dma_transfer_control_top.sv @@
// Top level of the double-buffer DMA transfer control block.
//
// Each request returns one result showing the channel registers after it.
// Completion, clear, rejected and zero-count start requests go straight to
// the emit state after acceptance. A start whose count fits one frame while
// at most one frame is programmed is answered by the split unit from its
// idle state. Any other start runs through one shared adder: a frame count
// of two or more is first checked by a 32-step restoring division plus a
// check state, and a search, entered when that check fails or a single
// frame does not fit the count, walks the product of frames and elements one
// add per cycle. Input ready is high only while no request is being worked
// on and returns in the cycle after the result is loaded; a finished result
// may still wait in the output register.
`default_nettype none
module double_buffer_dma_transfer_control_top import dbdma_pkg::*; #(
  parameter logic [CountW-1:0] XferLimit  = MaxTransferBytes,
  parameter logic [CntW-1:0]   CountLimit = MaxCount
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [1:0]  cfg_wdata_i,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [1:0]  kind_i,
  input  wire  [31:0] buffer_address_i,
  input  wire  [31:0] size_bytes_i,
  input  wire         transfer_error_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] element_count_o,
  output logic [15:0] frame_count_o,
  output logic [31:0] source_address_o,
  output logic [31:0] dest_address_o,
  output logic        channel_enable_o,
  output logic        auto_reload_o,
  output logic        end_prog_o,
  output logic [1:0]  buffers_pending_o,
  output logic [1:0]  callback_count_o
);

  top_state_e        state_q, state_d;
  logic              tx_dir_q;
  logic [1:0]        esize_q;
  logic [1:0]        pending_q, pending_d;
  logic [CntW-1:0]   elem_q, elem_d;
  logic [CntW-1:0]   frm_q, frm_d;
  logic [31:0]       src_q, src_d;
  logic [31:0]       dst_q, dst_d;
  logic              en_q, en_d;
  logic              ai_q, ai_d;
  logic              ep_q, ep_d;
  status_e           status_q, status_d;
  logic [1:0]        cb_q, cb_d;
  logic              out_valid_q, out_valid_d;
  logic              out_load;

  logic              accept;
  logic [CountW-1:0] count;
  logic [1:0]        pending_dec;
  logic [1:0]        pending_inc;
  split_req_t        split_req;
  split_rsp_t        split_rsp;

  assign in_ready_o  = (state_q == TOP_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign pending_inc = pending_q + 2'd1;
  assign pending_dec = (pending_q == 2'd0) ? 2'd0 : pending_q - 2'd1;

  always_comb begin
    unique case (esize_q)
      ESIZE_HALF: count = {1'b0, size_bytes_i[31:1]};
      ESIZE_WORD: count = {2'b00, size_bytes_i[31:2]};
      default:    count = size_bytes_i;
    endcase
  end

  wire start_ok  = (size_bytes_i <= XferLimit) && (pending_q < 2'd2);
  wire need_split = accept && (kind_i == KIND_START) && start_ok && (count != '0);

  assign split_req.start  = need_split;
  assign split_req.count  = count;
  assign split_req.frames = frm_q;

  dbdma_split #(
    .CountLimit (CountLimit)
  ) u_split (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (split_req),
    .rsp_o  (split_rsp)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      TOP_IDLE: begin
        if (need_split) begin
          state_d = TOP_SPLIT;
        end else if (accept) begin
          state_d = TOP_EMIT;
        end
      end
      TOP_SPLIT: begin
        if (split_rsp.done) begin
          state_d = TOP_EMIT;
        end
      end
      TOP_EMIT: begin
        if (out_load) begin
          state_d = TOP_IDLE;
        end
      end
    endcase
  end

  assign out_load = (state_q == TOP_EMIT) && (!out_valid_q || out_ready_i);

  // Channel register updates.
  always_comb begin
    pending_d = pending_q;
    elem_d    = elem_q;
    frm_d     = frm_q;
    src_d     = src_q;
    dst_d     = dst_q;
    en_d      = en_q;
    ai_d      = ai_q;
    ep_d      = ep_q;
    status_d  = status_q;
    cb_d      = cb_q;
    if (accept) begin
      status_d = ST_OK;
      cb_d     = 2'd0;
      unique case (kind_i)
        KIND_START: begin
          if (size_bytes_i > XferLimit) begin
            status_d = ST_OVERFLOW;
          end else if (pending_q >= 2'd2) begin
            status_d = ST_BUSY;
          end else begin
            if (tx_dir_q) begin
              src_d = buffer_address_i;
            end else begin
              dst_d = buffer_address_i;
            end
            if (count == '0) begin
              pending_d = pending_inc;
              en_d      = 1'b1;
              ai_d      = (pending_inc == 2'd2);
              ep_d      = (pending_inc == 2'd2);
            end
          end
        end
        KIND_COMPLETE: begin
          if (transfer_error_i) begin
            en_d      = 1'b0;
            ai_d      = 1'b0;
            cb_d      = pending_q;
            pending_d = 2'd0;
          end else begin
            pending_d = pending_dec;
            if (pending_dec == 2'd1) begin
              en_d = 1'b1;
              ai_d = 1'b0;
            end else if (pending_dec == 2'd0) begin
              en_d = 1'b0;
              ai_d = 1'b0;
            end
            cb_d = 2'd1;
          end
        end
        KIND_CLEAR: begin
          en_d      = 1'b0;
          ai_d      = 1'b0;
          ep_d      = 1'b0;
          pending_d = 2'd0;
        end
        default: begin
        end
      endcase
    end else if ((state_q == TOP_SPLIT) && split_rsp.done) begin
      if (split_rsp.ok) begin
        elem_d    = split_rsp.elements;
        frm_d     = split_rsp.frames;
        pending_d = pending_inc;
        en_d      = 1'b1;
        ai_d      = (pending_inc == 2'd2);
        ep_d      = (pending_inc == 2'd2);
      end else begin
        status_d = ST_NO_SPLIT;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TOP_IDLE;
      tx_dir_q    <= 1'b0;
      esize_q     <= 2'd0;
      pending_q   <= 2'd0;
      elem_q      <= '0;
      frm_q       <= '0;
      src_q       <= '0;
      dst_q       <= '0;
      en_q        <= 1'b0;
      ai_q        <= 1'b0;
      ep_q        <= 1'b0;
      status_q    <= ST_OK;
      cb_q        <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pending_q   <= pending_d;
      elem_q      <= elem_d;
      frm_q       <= frm_d;
      src_q       <= src_d;
      dst_q       <= dst_d;
      en_q        <= en_d;
      ai_q        <= ai_d;
      ep_q        <= ep_d;
      status_q    <= status_d;
      cb_q        <= cb_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_TX_DIRECTION) begin
          tx_dir_q <= cfg_wdata_i[0];
        end else if (cfg_index_i == CFG_ELEMENT_SIZE) begin
          esize_q <= cfg_wdata_i;
        end
      end
    end
  end

  // Result snapshot; the channel registers may move on after this.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_o          <= status_q;
      element_count_o   <= elem_q;
      frame_count_o     <= frm_q;
      source_address_o  <= src_q;
      dest_address_o    <= dst_q;
      channel_enable_o  <= en_q;
      auto_reload_o     <= ai_q;
      end_prog_o        <= ep_q;
      buffers_pending_o <= pending_q;
      callback_count_o  <= cb_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

@@ rtl/dbdma_split.sv @@
// Splits an element count into elements per frame and frames per block.
`default_nettype none
module dbdma_split import dbdma_pkg::*; #(
  parameter logic [CntW-1:0] CountLimit = MaxCount
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  split_req_t req_i,
  output split_rsp_t rsp_o
);

  split_state_e      state_q, state_d;
  logic [CntW:0]     rem_q, rem_d;
  logic [CountW-1:0] quo_q, quo_d;
  logic [4:0]        bitcnt_q, bitcnt_d;
  logic [CntW:0]     d_q, d_d;
  logic [CntW-1:0]   q_q, q_d;
  logic [ProdW-1:0]  p_q, p_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CntW-1:0]   fr_q, fr_d;
  split_rsp_t        rsp_q, rsp_d;

  // One adder serves both the restoring divider and the product walk.
  logic [ProdW-1:0] add_a, add_b, add_sum;
  logic             add_sub;
  logic [CntW:0]    shifted;
  logic             div_ge;
  logic             p_gt, p_eq;
  logic             fr_fits, div_ok, search_end;

  assign add_sum = add_a + (add_sub ? ~add_b : add_b) + {{(ProdW-1){1'b0}}, add_sub};
  assign shifted = {rem_q[CntW-1:0], quo_q[CountW-1]};
  assign div_ge  = ~add_sum[ProdW-1];
  assign p_gt    = p_q > {2'b00, count_q};
  assign p_eq    = p_q == {2'b00, count_q};
  assign fr_fits = req_i.count <= {{(CountW-CntW){1'b0}}, CountLimit};
  assign div_ok  = (rem_q == '0) && (quo_q <= {{(CountW-CntW){1'b0}}, CountLimit});
  assign search_end = (d_q > {1'b0, CountLimit}) || (q_q == '0);

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b1;
    if (state_q == SP_DIV) begin
      add_a = {{(ProdW-CntW-1){1'b0}}, shifted};
      add_b = {{(ProdW-CntW){1'b0}}, fr_q};
    end else if (p_gt) begin
      add_a = p_q;
      add_b = {{(ProdW-CntW-1){1'b0}}, d_q};
    end else begin
      add_a   = p_q;
      add_b   = {{(ProdW-CntW){1'b0}}, q_q};
      add_sub = 1'b0;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SP_IDLE: begin
        if (req_i.start) begin
          if (req_i.frames > 16'd1) begin
            state_d = SP_DIV;
          end else if (!fr_fits) begin
            state_d = SP_SEARCH;
          end
        end
      end
      SP_DIV: begin
        if (bitcnt_q == 5'd31) begin
          state_d = SP_CHECK;
        end
      end
      SP_CHECK: begin
        state_d = div_ok ? SP_IDLE : SP_SEARCH;
      end
      SP_SEARCH: begin
        if (search_end || p_eq) begin
          state_d = SP_IDLE;
        end
      end
    endcase
  end

  // Datapath and response.
  always_comb begin
    rem_d    = rem_q;
    quo_d    = quo_q;
    bitcnt_d = bitcnt_q;
    d_d      = d_q;
    q_d      = q_q;
    p_d      = p_q;
    count_d  = count_q;
    fr_d     = fr_q;
    rsp_d    = '0;
    unique case (state_q)
      SP_IDLE: begin
        if (req_i.start) begin
          count_d = req_i.count;
          fr_d    = req_i.frames;
          if (req_i.frames > 16'd1) begin
            rem_d    = '0;
            quo_d    = req_i.count;
            bitcnt_d = '0;
          end else if (fr_fits) begin
            rsp_d.done     = 1'b1;
            rsp_d.ok       = 1'b1;
            rsp_d.elements = req_i.count[CntW-1:0];
            rsp_d.frames   = 16'd1;
          end else begin
            // Walk starts at two frames with the largest element count.
            d_d = 17'd2;
            q_d = CountLimit;
            p_d = {{(ProdW-CntW-1){1'b0}}, CountLimit, 1'b0};
          end
        end
      end
      SP_DIV: begin
        rem_d    = div_ge ? add_sum[CntW:0] : shifted;
        quo_d    = {quo_q[CountW-2:0], div_ge};
        bitcnt_d = bitcnt_q + 5'd1;
      end
      SP_CHECK: begin
        if (div_ok) begin
          rsp_d.done     = 1'b1;
          rsp_d.ok       = 1'b1;
          rsp_d.elements = quo_q[CntW-1:0];
          rsp_d.frames   = fr_q;
        end else begin
          d_d = 17'd1;
          q_d = CountLimit;
          p_d = {{(ProdW-CntW){1'b0}}, CountLimit};
        end
      end
      SP_SEARCH: begin
        // p tracks d * q; q only falls and d only rises, so the first exact
        // hit is the smallest frame count with elements in range.
        if (search_end) begin
          rsp_d.done = 1'b1;
        end else if (p_eq) begin
          rsp_d.done     = 1'b1;
          rsp_d.ok       = 1'b1;
          rsp_d.elements = q_q;
          rsp_d.frames   = d_q[CntW-1:0];
        end else if (p_gt) begin
          q_d = q_q - 16'd1;
          p_d = add_sum;
        end else begin
          d_d = d_q + 17'd1;
          p_d = add_sum;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SP_IDLE;
      rsp_q   <= '0;
    end else begin
      state_q <= state_d;
      rsp_q   <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    bitcnt_q <= bitcnt_d;
    d_q      <= d_d;
    q_q      <= q_d;
    p_q      <= p_d;
    count_q  <= count_d;
    fr_q     <= fr_d;
  end

  assign rsp_o = rsp_q;

endmodule
`default_nettype wire
